@@ rtl/sds_pkg.sv @@
package sds_pkg;

    localparam int DataWidth  = 32;
    localparam int CountWidth = $clog2(DataWidth);

    typedef struct packed {
        logic signed [DataWidth-1:0] numerator;
        logic signed [DataWidth-1:0] denominator;
    } sds_in_t;

    typedef struct packed {
        logic signed [DataWidth-1:0] quotient;
        logic                        overflow;
        logic                        divide_by_zero;
    } sds_out_t;

    typedef struct packed {
        logic load;
        logic step;
    } sds_ctrl_t;

endpackage

@@ rtl/sds_cell.sv @@
module sds_cell
    import sds_pkg::*;
(
    input  logic      clk,
    input  sds_ctrl_t ctrl,
    input  logic      a_bit,
    input  logic      b_bit,
    input  logic      s_in,
    input  logic      q_in,
    input  logic      borrow_in,
    input  logic      sel,
    output logic      r_bit,
    output logic      q_bit,
    output logic      borrow_out
);

    logic r_reg;
    logic q_reg;
    logic d_reg;
    logic diff;

    // one bit of the trial subtraction, borrow ripples upward
    assign diff       = s_in ^ d_reg ^ borrow_in;
    assign borrow_out = (~s_in & d_reg) | (~(s_in ^ d_reg) & borrow_in);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            r_reg <= 1'b0;
            q_reg <= a_bit;
            d_reg <= b_bit;
        end
        else if (ctrl.step)
        begin
            r_reg <= sel ? diff : s_in;
            q_reg <= q_in;
        end
    end

    assign r_bit = r_reg;
    assign q_bit = q_reg;

endmodule

@@ rtl/sds_row.sv @@
module sds_row
    import sds_pkg::*;
(
    input  logic                 clk,
    input  sds_ctrl_t            ctrl,
    input  logic [DataWidth-1:0] mag_a,
    input  logic [DataWidth-1:0] mag_b,
    output logic [DataWidth-1:0] mag_q
);

    logic [DataWidth-1:0] r_bits;
    logic [DataWidth-1:0] q_bits;
    logic [DataWidth-1:0] s_bits;
    logic [DataWidth-1:0] qin_bits;
    logic [DataWidth:0]   borrow;
    logic                 sel;

    assign borrow[0] = 1'b0;
    assign sel       = ~borrow[DataWidth];

    // shifted remainder takes the next dividend bit, quotient bit enters at the bottom
    assign s_bits   = {r_bits[DataWidth-2:0], q_bits[DataWidth-1]};
    assign qin_bits = {q_bits[DataWidth-2:0], sel};

    genvar i;
    generate
        for (i = 0; i < DataWidth; i++)
        begin : g_cell
            sds_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .a_bit      (mag_a[i]),
                .b_bit      (mag_b[i]),
                .s_in       (s_bits[i]),
                .q_in       (qin_bits[i]),
                .borrow_in  (borrow[i]),
                .sel        (sel),
                .r_bit      (r_bits[i]),
                .q_bit      (q_bits[i]),
                .borrow_out (borrow[i+1])
            );
        end
    endgenerate

    assign mag_q = q_bits;

endmodule

@@ rtl/signed_divider_saturating.sv @@
// Signed truncating divider with saturation. An operand pair is taken when start is
// high and busy is low; the quotient appears, after the divide and fix-up states, for
// one cycle with done high, and the receiver cannot stall it. The row of bit cells
// retires one quotient bit per cycle as a restoring divider on the operand magnitudes,
// followed by a sign fix-up state. busy drops in the cycle that done rises, so the next
// transfer may start while a result is shown. Most negative over minus one gives the
// largest positive value with overflow set; a zero divisor gives quotient zero with
// divide_by_zero set.
module signed_divider_saturating
    import sds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  sds_in_t  operands,
    output logic     busy,
    output logic     done,
    output sds_out_t result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CountWidth-1:0] cnt_reg;
    logic [CountWidth-1:0] cnt_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  neg_reg;
    logic                  dbz_reg;
    sds_out_t              result_reg;
    sds_out_t              result_next;

    logic [DataWidth-1:0]  num_u;
    logic [DataWidth-1:0]  den_u;
    logic [DataWidth-1:0]  mag_a;
    logic [DataWidth-1:0]  mag_b;
    logic [DataWidth-1:0]  mag_q;
    logic                  accept;
    sds_ctrl_t             ctrl;

    assign accept = start && (state_reg == ST_IDLE);
    assign num_u  = operands.numerator;
    assign den_u  = operands.denominator;
    assign mag_a  = num_u[DataWidth-1] ? (~num_u + DataWidth'(1)) : num_u;
    assign mag_b  = den_u[DataWidth-1] ? (~den_u + DataWidth'(1)) : den_u;

    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == ST_DIV);

    sds_row u_row (
        .clk   (clk),
        .ctrl  (ctrl),
        .mag_a (mag_a),
        .mag_b (mag_b),
        .mag_q (mag_q)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DIV;
                    cnt_next   = CountWidth'(DataWidth - 1);
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - CountWidth'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sign fix-up and the two special cases
    always_comb
    begin
        result_next.quotient       = mag_q;
        result_next.overflow       = 1'b0;
        result_next.divide_by_zero = 1'b0;
        if (dbz_reg)
        begin
            result_next.quotient       = '0;
            result_next.divide_by_zero = 1'b1;
        end
        else if (neg_reg)
        begin
            result_next.quotient = ~mag_q + DataWidth'(1);
        end
        else if (mag_q[DataWidth-1])
        begin
            result_next.quotient = {1'b0, {(DataWidth-1){1'b1}}};
            result_next.overflow = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= num_u[DataWidth-1] ^ den_u[DataWidth-1];
            dbz_reg <= (den_u == '0);
        end
        if (state_reg == ST_FIX)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ bench/tb.sv @@
module tb;

    import sds_pkg::*;

    localparam logic signed [DataWidth-1:0] MinWord = {1'b1, {(DataWidth-1){1'b0}}};
    localparam logic signed [DataWidth-1:0] MaxWord = {1'b0, {(DataWidth-1){1'b1}}};
    localparam int RandomCount  = 1876;
    localparam int CalmTail     = 300;
    localparam int DrainAt      = 900;
    localparam int SettleCycles = 40;
    localparam int StallLimit   = 2000;

    typedef struct packed {
        logic signed [DataWidth-1:0] num;
        logic signed [DataWidth-1:0] den;
        logic                        known;
        sds_out_t                    want;
    } div_vector_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    sds_in_t  operands;
    logic     busy;
    logic     done;
    sds_out_t result;

    sds_out_t    pending_quotients[$];
    div_vector_t div_vectors[$];
    int          mismatches;
    int          stall_cycles;

    signed_divider_saturating uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operands (operands),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic sds_out_t divide_expected(input sds_in_t op);
        logic [DataWidth-1:0] a;
        logic [DataWidth-1:0] b;
        logic [DataWidth-1:0] mag_a;
        logic [DataWidth-1:0] mag_b;
        logic [DataWidth-1:0] mag_q;
        sds_out_t             r;
        a = op.numerator;
        b = op.denominator;
        r = '0;
        if (b == '0)
        begin
            r.divide_by_zero = 1'b1;
        end
        else
        begin
            mag_a = a[DataWidth-1] ? -a : a;
            mag_b = b[DataWidth-1] ? -b : b;
            mag_q = mag_a / mag_b;
            if (a[DataWidth-1] != b[DataWidth-1])
            begin
                r.quotient = -mag_q;
            end
            else if (mag_q > MaxWord)
            begin
                r.quotient = MaxWord;
                r.overflow = 1'b1;
            end
            else
            begin
                r.quotient = mag_q;
            end
        end
        return r;
    endfunction

    function automatic void add_vector(input logic signed [DataWidth-1:0] n,
                                       input logic signed [DataWidth-1:0] d,
                                       input logic known,
                                       input logic signed [DataWidth-1:0] q,
                                       input logic ovf,
                                       input logic dbz);
        div_vector_t v;
        v.num                 = n;
        v.den                 = d;
        v.known               = known;
        v.want.quotient       = q;
        v.want.overflow       = ovf;
        v.want.divide_by_zero = dbz;
        div_vectors.push_back(v);
    endfunction

    function automatic logic signed [DataWidth-1:0] edge_word();
        case ($urandom_range(0, 5))
            0: return MinWord;
            1: return MaxWord;
            2: return '0;
            3: return 1;
            4: return -1;
            default: return MinWord + 1;
        endcase
    endfunction

    function automatic logic signed [DataWidth-1:0] small_word(input int unsigned lim);
        logic signed [DataWidth-1:0] w;
        w = $urandom_range(0, lim);
        return $urandom_range(0, 1) ? -w : w;
    endfunction

    function automatic sds_in_t random_operands();
        sds_in_t op;
        op.numerator   = $urandom;
        op.denominator = $urandom;
        case ($urandom_range(0, 9))
            4:
            begin
                op.numerator   = small_word(300);
                op.denominator = small_word(300);
            end
            5: op.denominator = small_word(16);
            6: op.denominator = '0;
            7:
            begin
                op.numerator = MinWord;
                case ($urandom_range(0, 3))
                    0: op.denominator = -1;
                    1: op.denominator = 1;
                    2: op.denominator = edge_word();
                    default: ;
                endcase
            end
            8:
            begin
                op.denominator = 1 << $urandom_range(0, DataWidth - 1);
                if ($urandom_range(0, 1))
                    op.denominator = -op.denominator;
            end
            9:
            begin
                op.numerator   = edge_word();
                op.denominator = edge_word();
            end
            default: ;
        endcase
        return op;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic transfer(input sds_in_t op, input sds_out_t want);
        start    <= 1'b1;
        operands <= op;
        do
            @(posedge clk);
        while (busy);
        pending_quotients.push_back(want);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        sds_out_t want;
        if (done)
        begin
            if (pending_quotients.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d ovf %0b dbz %0b",
                         $time, result.quotient, result.overflow, result.divide_by_zero);
                mismatches++;
            end
            else
            begin
                want = pending_quotients.pop_front();
                if (result.quotient !== want.quotient)
                begin
                    $display("%0t: quotient mismatch, expected %0d, actual %0d",
                             $time, want.quotient, result.quotient);
                    mismatches++;
                end
                if (result.overflow !== want.overflow)
                begin
                    $display("%0t: overflow mismatch, expected %0b, actual %0b",
                             $time, want.overflow, result.overflow);
                    mismatches++;
                end
                if (result.divide_by_zero !== want.divide_by_zero)
                begin
                    $display("%0t: divide_by_zero mismatch, expected %0b, actual %0b",
                             $time, want.divide_by_zero, result.divide_by_zero);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= StallLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        sds_in_t op;
        int      gap;
        mismatches   = 0;
        stall_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        operands     = '0;

        // extremes, truncation signs and both special cases
        add_vector(0, 0, 1, 0, 0, 1);
        add_vector(MaxWord, 0, 1, 0, 0, 1);
        add_vector(MinWord, 0, 1, 0, 0, 1);
        add_vector(-1, 0, 1, 0, 0, 1);
        add_vector(MinWord, -1, 1, MaxWord, 1, 0);
        add_vector(MinWord + 1, -1, 1, MaxWord, 0, 0);
        add_vector(MinWord, 1, 1, MinWord, 0, 0);
        add_vector(MaxWord, 1, 1, MaxWord, 0, 0);
        add_vector(MaxWord, -1, 1, -MaxWord, 0, 0);
        add_vector(MinWord, MinWord, 1, 1, 0, 0);
        add_vector(MaxWord, MaxWord, 1, 1, 0, 0);
        add_vector(MaxWord, MinWord, 1, 0, 0, 0);
        add_vector(MinWord, MaxWord, 1, -1, 0, 0);
        add_vector(7, 2, 1, 3, 0, 0);
        add_vector(-7, 2, 1, -3, 0, 0);
        add_vector(7, -2, 1, -3, 0, 0);
        add_vector(-7, -2, 1, 3, 0, 0);
        add_vector(0, -1, 1, 0, 0, 0);
        add_vector(0, MinWord, 1, 0, 0, 0);
        add_vector(-1, MinWord, 1, 0, 0, 0);
        add_vector(MinWord, 2, 0, 0, 0, 0);
        add_vector(MaxWord, 2, 0, 0, 0, 0);
        add_vector(32'h1234_5678, 32'h0000_0123, 0, 0, 0, 0);
        add_vector(-100000, 7, 0, 0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (div_vectors[i])
        begin
            op.numerator   = div_vectors[i].num;
            op.denominator = div_vectors[i].den;
            transfer(op, div_vectors[i].known ? div_vectors[i].want : divide_expected(op));
        end

        for (int i = 0; i < RandomCount; i++)
        begin
            op = random_operands();
            if (i == DrainAt)
            begin
                start <= 1'b0;
                do
                    @(negedge clk);
                while (pending_quotients.size() != 0);
            end
            else if (i < RandomCount - CalmTail && (i / 150) % 2 == 0
                     && $urandom_range(0, 2) == 0)
            begin
                gap = $urandom_range(1, 17);
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            transfer(op, divide_expected(op));
        end
        start <= 1'b0;

        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
